// File: rtl/hss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hss_pkg: shared types and constants of the half-step sequencer
// Item structs for both channels, event and limit codes, coil patterns.
// ----------------------------------------------------------------------------
package hss_pkg;

  localparam logic [1:0] OP_CHOP = 2'd0;
  localparam logic [1:0] OP_STEP = 2'd1;
  localparam logic [1:0] OP_LOAD = 2'd2;

  localparam logic [1:0] LIMIT_FWD_HIT = 2'd1;
  localparam logic [1:0] LIMIT_REV_HIT = 2'd2;

  localparam logic [5:0] DRIVE_OFF = 6'd54;
  localparam logic [1:0] CHOP_RESTART = 2'd1;

  typedef struct packed {
    logic [1:0] opcode;
    logic [6:0] move_steps;
    logic       move_forward;
    logic [1:0] limit_status;
  } hss_in_t;

  typedef struct packed {
    logic [5:0]  coil_drive;
    logic [2:0]  phase_index;
    logic [15:0] position;
    logic [6:0]  moves_left;
    logic        step_timer_run;
  } hss_out_t;

  // bits I01,I11,P1,I02,I12,P2 from msb
  function automatic logic [5:0] drive_pattern(input logic [2:0] phase);
    logic [5:0] pat;
    unique case (phase)
      3'd0: pat = 6'd15;
      3'd1: pat = 6'd45;
      3'd2: pat = 6'd49;
      3'd3: pat = 6'd37;
      3'd4: pat = 6'd6;
      3'd5: pat = 6'd36;
      3'd6: pat = 6'd56;
      default: pat = 6'd44;
    endcase
    return pat;
  endfunction

endpackage

// File: rtl/stepper_half_step_sequencer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_half_step_sequencer_top: one stepper axis, half-step drive
// Input register, event update and result register for chop, step and load.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while its output is not stalled,
// and returns exactly one result per item: the item waits in the input
// register, then the event is applied to the axis state and the result is
// captured in the output register. The result shows the state after the
// event. A stalled output holds its result while the input register can still
// take one more item; both then stall until the result is taken. Reset puts
// the axis at phase 0, position 0, no move loaded, chop phase 1.
module stepper_half_step_sequencer_top
  import hss_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  hss_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output hss_out_t out_data
);

  logic     in_full;
  hss_in_t  in_item;
  logic     advance;
  hss_out_t result;

  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_item <= in_data;
    end
  end

  hss_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (in_item),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

endmodule

// File: rtl/hss_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hss_core: axis state and event update
// Holds chop phase, half-step phase, move count, direction and position;
// applies one event per fire and forms the result from the updated state.
// ----------------------------------------------------------------------------
module hss_core
  import hss_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     fire,
  input  hss_in_t  item,
  output hss_out_t result
);

  logic [1:0]  chop_phase, chop_phase_next;
  logic [2:0]  step_phase, step_phase_next;
  logic [6:0]  remaining, remaining_next;
  logic        direction, direction_next;
  logic [15:0] step_position, step_position_next;

  always_comb begin
    chop_phase_next    = chop_phase;
    step_phase_next    = step_phase;
    remaining_next     = remaining;
    direction_next     = direction;
    step_position_next = step_position;
    unique case (item.opcode)
      OP_CHOP: begin
        chop_phase_next = chop_phase + 2'd1;
      end
      OP_STEP: begin
        chop_phase_next = CHOP_RESTART;
        if (remaining != 7'd0) begin
          if (direction) begin
            if (item.limit_status != LIMIT_FWD_HIT) begin
              step_phase_next    = step_phase + 3'd1;
              step_position_next = step_position + 16'd1;
            end
          end else begin
            if (item.limit_status != LIMIT_REV_HIT) begin
              step_phase_next = step_phase - 3'd1;
              // position floors at zero
              if (step_position != 16'd0) begin
                step_position_next = step_position - 16'd1;
              end
            end
          end
          // a blocked step still uses up one half-step
          remaining_next = remaining - 7'd1;
        end
      end
      OP_LOAD: begin
        remaining_next = item.move_steps;
        direction_next = item.move_forward;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chop_phase    <= CHOP_RESTART;
      step_phase    <= 3'd0;
      remaining     <= 7'd0;
      direction     <= 1'b0;
      step_position <= 16'd0;
    end else if (fire) begin
      chop_phase    <= chop_phase_next;
      step_phase    <= step_phase_next;
      remaining     <= remaining_next;
      direction     <= direction_next;
      step_position <= step_position_next;
    end
  end

  always_comb begin
    result.coil_drive     = (chop_phase_next != 2'd0) ? drive_pattern(step_phase_next)
                                                      : DRIVE_OFF;
    result.phase_index    = step_phase_next;
    result.position       = step_position_next;
    result.moves_left     = remaining_next;
    result.step_timer_run = (remaining_next != 7'd0);
  end

  a_step_restarts_chop: assert property (@(posedge clk) disable iff (rst)
    fire && item.opcode == OP_STEP |=> chop_phase == CHOP_RESTART)
    else $error("chop phase not restarted by step tick");

  a_count_only_loaded_up: assert property (@(posedge clk) disable iff (rst)
    !(fire && item.opcode == OP_LOAD) |=> remaining <= $past(remaining))
    else $error("move count grew without a load");

  a_idle_holds_state: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(step_position) && $stable(step_phase) && $stable(remaining))
    else $error("axis state changed without an item");

  a_phase_single_step: assert property (@(posedge clk) disable iff (rst)
    fire |=> step_phase == $past(step_phase) ||
             step_phase == 3'($past(step_phase) + 3'd1) ||
             step_phase == 3'($past(step_phase) - 3'd1))
    else $error("half-step phase jumped more than one place");

endmodule
